// ----- sv/wheel_event_to_pot_mapper_defines.svh -----
// Assertion macros for the wheel event to pot mapper.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef WHEEL_EVENT_TO_POT_MAPPER_DEFINES_SVH
`define WHEEL_EVENT_TO_POT_MAPPER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WEPM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WEPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/wepm_pkg.sv -----
// Shared types, codes and mode tables for the wheel event to pot mapper.
// No dependencies.
package wepm_pkg;

    localparam int AXIS_BITS_DEF = 16;

    // input and result words
    typedef struct packed {
        logic        req_type;
        logic [9:0]  code;
        logic [15:0] value;
    } t_in_word;

    typedef struct packed {
        logic        pot_write;
        logic        pot_target;
        logic [7:0]  pot_data;
        logic        spring_update;
        logic [15:0] spring_level;
        logic [3:0]  effect_start_mask;
        logic [3:0]  effect_stop_mask;
        logic [1:0]  steer_mode_now;
        logic [1:0]  drive_mode_now;
    } t_out_word;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV1,
        ST_CALC,
        ST_PREP,
        ST_DIV2,
        ST_FIN
    } t_state;

    // request kinds
    localparam logic REQ_BUTTON = 1'b0;

    // mode codes
    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_HALF    = 2'd1;
    localparam logic [1:0] MODE_QUARTER = 2'd2;

    // button codes
    localparam logic [9:0] BTN_STEER_FULL    = 10'd288;
    localparam logic [9:0] BTN_STEER_HALF    = 10'd289;
    localparam logic [9:0] BTN_STEER_QUARTER = 10'd291;
    localparam logic [9:0] BTN_DRIVE_HALF    = 10'd292;
    localparam logic [9:0] BTN_DRIVE_QUARTER = 10'd293;
    localparam logic [9:0] BTN_DRIVE_FULL    = 10'd298;

    // axis numbers
    localparam logic [9:0] AXIS_STEER = 10'd0;
    localparam logic [9:0] AXIS_GAS   = 10'd1;
    localparam logic [9:0] AXIS_BRAKE = 10'd2;

    // pot values
    localparam logic [7:0] POT_START = 8'd63;
    localparam logic [7:0] POT_MAX   = 8'd127;
    localparam logic [7:0] GAS_CAP   = 8'd70;

    // effect bits
    localparam logic [3:0] EFF_PEDAL_ON   = 4'b0001;
    localparam logic [3:0] EFF_PEDAL_IDLE = 4'b0010;
    localparam logic [3:0] EFF_DRIVE_HALF = 4'b0100;
    localparam logic [3:0] EFF_DRIVE_FULL = 4'b1000;

    // spring scale: 65535 = 127 * 516 + 3
    localparam logic [15:0] SPRING_DIV  = 16'd127;
    localparam logic [7:0]  SPRING_BIAS = 8'd127;

    // steer full-scale range
    function automatic logic [15:0] steer_range(input logic [1:0] m);
        case (m)
            MODE_FULL: steer_range = 16'd65535;
            MODE_HALF: steer_range = 16'd32767;
            default:   steer_range = 16'd16383;
        endcase
    endfunction

    // 127 minus steer offset
    function automatic logic [8:0] steer_base(input logic [1:0] m);
        case (m)
            MODE_FULL: steer_base = 9'd127;
            MODE_HALF: steer_base = 9'd191;
            default:   steer_base = 9'd318;
        endcase
    endfunction

    // pedal full-scale range
    function automatic logic [15:0] drive_range(input logic [1:0] m);
        case (m)
            MODE_FULL: drive_range = 16'd510;
            MODE_HALF: drive_range = 16'd1020;
            default:   drive_range = 16'd1275;
        endcase
    endfunction

    // 127 minus gas offset
    function automatic logic [7:0] gas_base(input logic [1:0] m);
        case (m)
            MODE_FULL: gas_base = 8'd126;
            MODE_HALF: gas_base = 8'd94;
            default:   gas_base = 8'd88;
        endcase
    endfunction

    // negated brake offset
    function automatic logic [7:0] brake_add(input logic [1:0] m);
        case (m)
            MODE_FULL: brake_add = 8'd0;
            MODE_HALF: brake_add = 8'd32;
            default:   brake_add = 8'd38;
        endcase
    endfunction

endpackage

// ----- sv/wheel_event_to_pot_mapper.sv -----
// Wheel event to pot mapper: top level with sequencer and bit-serial divider.
// Depends on wepm_pkg.
//
// One event in, one result word out. Button and other non-axis events skip the
// divider and give their word straight from the load state; a steer event runs
// the divider once; a gas or brake event runs it twice.
// The sequencer returns to idle for the next event once the word is registered.
// One restoring divider retires one quotient bit per cycle over AXIS_BITS+7
// bits: once for the axis scaling and, for pedals, once more for the spring
// level. The result sits in an output register, so a stalled consumer only
// holds the sequencer in its final state.
module wheel_event_to_pot_mapper
    import wepm_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int DW = AXIS_BITS + 7;   // dividend / quotient width
    localparam int PW = DW + 2;          // signed pot value width
    localparam int CW = $clog2(DW);      // bit counter width

    // control state
    t_state          r_state, n_state;
    logic [1:0]      r_steer_mode;
    logic [1:0]      r_drive_mode;
    logic [7:0]      r_last_steer;
    logic [15:0]     r_last_drive;
    logic            r_out_valid;

    // payload
    logic            r_req;
    logic [9:0]      r_code;
    logic [AXIS_BITS-1:0] r_v;
    logic [DW-1:0]   r_dq,   n_dq;
    logic [15:0]     r_rem,  n_rem;
    logic [15:0]     r_dvs,  n_dvs;
    logic [CW-1:0]   r_cnt,  n_cnt;
    logic signed [PW-1:0] r_pv, n_pv;
    logic [DW-1:0]   r_ax,   n_ax;
    logic            r_xneg, n_xneg;
    t_out_word       r_out;

    // decodes
    logic w_accept, w_out_free, w_fin, w_step, w_load, w_calc, w_prep;
    logic w_is_steer, w_is_gas, w_axis_live;

    // divider step
    logic [16:0] w_trial;
    logic        w_ge;
    logic [16:0] w_diff;

    // calc / prep
    logic [DW-1:0]        w_prod;
    logic signed [PW-1:0] w_qs;
    logic signed [PW-1:0] w_s;
    logic signed [PW:0]   w_x;
    logic signed [PW:0]   w_xabs;
    logic [DW-1:0]        w_ax_n;

    // finish
    logic signed [PW-1:0] w_capped;
    logic [15:0]          w_d16;
    logic [15:0]          w_ax16;
    logic [15:0]          w_q16;
    logic [15:0]          w_mag16;
    logic                 w_press;
    logic [1:0]           w_steer_next;
    logic [1:0]           w_drive_next;
    t_out_word            w_res;

    assign w_is_steer  = (r_code == AXIS_STEER);
    assign w_is_gas    = (r_code == AXIS_GAS);
    assign w_axis_live = r_req && (r_code inside {AXIS_STEER, AXIS_GAS, AXIS_BRAKE});
    assign w_out_free  = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_LOAD;
            ST_LOAD: n_state = w_axis_live ? ST_DIV1 : ST_FIN;
            ST_DIV1: if (r_cnt == '0) n_state = ST_CALC;
            ST_CALC: n_state = w_is_steer ? ST_FIN : ST_PREP;
            ST_PREP: n_state = ST_DIV2;
            ST_DIV2: if (r_cnt == '0) n_state = ST_FIN;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        w_step     = 1'b0;
        w_calc     = 1'b0;
        w_prep     = 1'b0;
        w_fin      = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_LOAD: w_load     = 1'b1;
            ST_DIV1: w_step     = 1'b1;
            ST_CALC: w_calc     = 1'b1;
            ST_PREP: w_prep     = 1'b1;
            ST_DIV2: w_step     = 1'b1;
            ST_FIN:  w_fin      = w_out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // restoring divide, one bit a cycle
    assign w_trial = {r_rem, r_dq[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // v * 127 as (v << 7) - v
    assign w_prod = {r_v, 7'b0} - DW'(r_v);

    // scaled quotient and pot value
    assign w_qs = $signed({2'b00, r_dq});
    assign w_s  = $signed(PW'(steer_base(r_steer_mode))) - w_qs;

    // spring numerator sign and magnitude
    always_comb begin
        if (w_is_gas) begin
            w_x = {r_pv, 1'b0} - $signed((PW+1)'(SPRING_BIAS));
        end else begin
            w_x = $signed((PW+1)'(SPRING_BIAS)) - {r_pv, 1'b0};
        end
        w_xabs = w_x[PW] ? -w_x : w_x;
        w_ax_n = DW'(w_xabs);
    end

    // datapath next values
    always_comb begin
        n_dq   = r_dq;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_pv   = r_pv;
        n_ax   = r_ax;
        n_xneg = r_xneg;
        if (w_load) begin
            n_dq  = w_prod;
            n_rem = '0;
            n_dvs = w_is_steer ? steer_range(r_steer_mode) : drive_range(r_drive_mode);
            n_cnt = CW'(DW - 1);
        end else if (w_step) begin
            n_rem = w_ge ? w_diff[15:0] : w_trial[15:0];
            n_dq  = {r_dq[DW-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
        end else if (w_calc) begin
            if (w_is_steer) begin
                // clamp to 0..127
                if (w_s[PW-1]) begin
                    n_pv = '0;
                end else if (|w_s[PW-2:7]) begin
                    n_pv = $signed(PW'(POT_MAX));
                end else begin
                    n_pv = w_s;
                end
            end else if (w_is_gas) begin
                n_pv = $signed(PW'(gas_base(r_drive_mode))) - w_qs;
            end else begin
                n_pv = w_qs + $signed(PW'(brake_add(r_drive_mode)));
            end
        end else if (w_prep) begin
            // divide 3*|x| by 127 for the spring remainder term
            n_xneg = w_x[PW];
            n_ax   = w_ax_n;
            n_dq   = {w_ax_n[DW-2:0], 1'b0} + w_ax_n;
            n_rem  = '0;
            n_dvs  = SPRING_DIV;
            n_cnt  = CW'(DW - 1);
        end
    end

    // spring: 516*|x| + floor(3*|x|/127), sign applied, low 16 bits
    assign w_ax16  = 16'(r_ax);
    assign w_q16   = 16'(r_dq);
    assign w_mag16 = {w_ax16[6:0], 9'b0} + {w_ax16[13:0], 2'b0} + w_q16;

    // gas is capped after the spring level is taken
    assign w_capped = (w_is_gas && (r_pv > $signed(PW'(GAS_CAP)))) ?
                      $signed(PW'(GAS_CAP)) : r_pv;
    assign w_d16    = 16'(w_capped);
    assign w_press  = (r_req == REQ_BUTTON) && (r_v == AXIS_BITS'(1));

    // result word and mode updates
    always_comb begin
        w_res        = '0;
        w_steer_next = r_steer_mode;
        w_drive_next = r_drive_mode;
        if (r_req == REQ_BUTTON) begin
            if (w_press) begin
                case (r_code)
                    BTN_STEER_FULL:    w_steer_next = MODE_FULL;
                    BTN_STEER_HALF:    w_steer_next = MODE_HALF;
                    BTN_STEER_QUARTER: w_steer_next = MODE_QUARTER;
                    default:           w_steer_next = r_steer_mode;
                endcase
                case (r_code)
                    BTN_DRIVE_FULL: begin
                        w_drive_next            = MODE_FULL;
                        w_res.effect_start_mask = EFF_DRIVE_FULL;
                    end
                    BTN_DRIVE_HALF: begin
                        w_drive_next            = MODE_HALF;
                        w_res.effect_start_mask = EFF_DRIVE_HALF;
                    end
                    BTN_DRIVE_QUARTER: w_drive_next = MODE_QUARTER;
                    default:           w_drive_next = r_drive_mode;
                endcase
            end
        end else if (w_is_steer) begin
            if (r_pv[7:0] != r_last_steer) begin
                w_res.pot_write  = 1'b1;
                w_res.pot_target = 1'b0;
                w_res.pot_data   = r_pv[7:0];
            end
        end else if (w_axis_live) begin
            if (r_pv != $signed(PW'(POT_START))) begin
                w_res.effect_stop_mask  = EFF_PEDAL_IDLE;
                w_res.effect_start_mask = EFF_PEDAL_ON;
            end else begin
                w_res.effect_stop_mask  = EFF_PEDAL_ON;
                w_res.effect_start_mask = EFF_PEDAL_IDLE;
            end
            w_res.spring_update = 1'b1;
            w_res.spring_level  = r_xneg ? (~w_mag16 + 16'd1) : w_mag16;
            if (w_d16 != r_last_drive) begin
                w_res.pot_write  = 1'b1;
                w_res.pot_target = 1'b1;
                w_res.pot_data   = w_d16[7:0];
            end
        end
        w_res.steer_mode_now = w_steer_next;
        w_res.drive_mode_now = w_drive_next;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_steer_mode <= MODE_FULL;
            r_drive_mode <= MODE_QUARTER;
            r_last_steer <= POT_START;
            r_last_drive <= 16'(POT_START);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_steer_mode <= w_steer_next;
                r_drive_mode <= w_drive_next;
                r_out_valid  <= 1'b1;
                if (w_res.pot_write && !w_res.pot_target) begin
                    r_last_steer <= w_res.pot_data;
                end
                if (w_res.pot_write && w_res.pot_target) begin
                    r_last_drive <= w_d16;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_in_data.req_type;
            r_code <= i_in_data.code;
            r_v    <= i_in_data.value[AXIS_BITS-1:0];
        end
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_cnt  <= n_cnt;
        r_pv   <= n_pv;
        r_ax   <= n_ax;
        r_xneg <= n_xneg;
        if (w_fin) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/wepm_checker.sv -----
// Port checker for the wheel event to pot mapper, bound to the top level.
// Depends on wepm_pkg and wheel_event_to_pot_mapper_defines.svh.
`include "wheel_event_to_pot_mapper_defines.svh"

module wepm_checker
    import wepm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // a stalled result word holds
    `WEPM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result word changed while stalled")

    // one event at a time: busy right after an accept
    `WEPM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")

    // no pot write means clean pot fields
    `WEPM_ASSERT_IMPL(a_no_write_clean, o_out_valid && !o_out_data.pot_write, o_out_data.pot_target == 1'b0 && o_out_data.pot_data == 8'd0, "pot fields set without write")

    // pedal words swap the two pedal effects
    `WEPM_ASSERT_IMPL(a_pedal_effects, o_out_valid && o_out_data.spring_update, (o_out_data.effect_stop_mask == EFF_PEDAL_IDLE && o_out_data.effect_start_mask == EFF_PEDAL_ON) || (o_out_data.effect_stop_mask == EFF_PEDAL_ON && o_out_data.effect_start_mask == EFF_PEDAL_IDLE), "bad pedal effect masks")

    // no spring update means no spring level and no stops
    `WEPM_ASSERT_IMPL(a_no_spring_clean, o_out_valid && !o_out_data.spring_update, o_out_data.spring_level == 16'd0 && o_out_data.effect_stop_mask == 4'd0, "spring fields set without update")

endmodule

bind wheel_event_to_pot_mapper wepm_checker u_wepm_checker (.*);
